// ----- rtl/ffca_pkg.sv -----
// ============================================================================
// ffca_pkg
// Shared types and codes for the first-fit contiguous slot allocator.
// ============================================================================
package ffca_pkg;

    // Default number of slots that the occupancy memory holds.
    localparam int MAX_SLOTS_DEFAULT = 64;

    // Hall size after reset.
    localparam logic [6:0] HALL_SIZE_RESET = 7'd64;

    // Request operations.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ALLOCATED    = 2'd0;
    localparam logic [1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [1:0] ST_FREED        = 2'd2;
    localparam logic [1:0] ST_FREE_INVALID = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [6:0] run_width;
        logic [5:0] free_start;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] run_start;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } state_t;

endpackage

// ----- rtl/first_fit_contiguous_allocator.sv -----
// ============================================================================
// first_fit_contiguous_allocator
// First-fit allocator of contiguous slot runs over a one-bit occupancy memory.
// ============================================================================
// The block keeps one occupancy bit per slot in a synchronous memory of
// MAX_SLOTS entries. After reset it clears that memory, one entry per
// cycle, and holds req_stall high meanwhile; hall size writes are taken
// during that pass. One request item is worked on at a time. An allocate
// item scans the hall one slot per cycle through the memory read port, then
// marks each slot of the granted run used in the write phase, then posts
// its result. A free item clears each slot of its run in the write phase,
// then posts its result. Width-zero items, invalid frees and allocates
// wider than the hall go straight to posting the result. The memory port
// takes one entry per cycle, which paces the clearing pass, the scan and
// the write phase. The result sits in an output register, so the next
// item is taken while a result still waits.
// ============================================================================
module first_fit_contiguous_allocator #(
    parameter int MAX_SLOTS = ffca_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ffca_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ffca_pkg::rsp_item_t rsp_item,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata
);
    import ffca_pkg::*;

    // Slot address width, width of the slot-count domain, and a working
    // width wide enough for both that domain and start plus width sums.
    localparam int IW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SW  = $clog2(MAX_SLOTS + 1);
    localparam int XW  = ((SW > 7) ? SW : 7) + 1;
    localparam logic [XW-1:0] MAX_SLOTS_X = XW'(MAX_SLOTS);
    localparam logic [IW-1:0] LAST_SLOT   = IW'(MAX_SLOTS - 1);

    // Control registers.
    state_t          state_reg, state_next;
    logic [6:0]      hall_size_reg, hall_size_next;
    logic [IW-1:0]   clr_idx_reg, clr_idx_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // Working registers of the item in progress.
    logic [6:0]      width_reg, width_next;
    logic [XW-1:0]   issue_reg, issue_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic [6:0]      run_reg, run_next;
    logic [IW-1:0]   wr_idx_reg, wr_idx_next;
    logic [6:0]      wr_left_reg, wr_left_next;
    logic            wr_val_reg, wr_val_next;
    rsp_item_t       res_reg, res_next;
    rsp_item_t       rsp_item_reg, rsp_item_next;

    // Occupancy memory.
    logic            slot_mem [MAX_SLOTS];
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic            mem_wdata;
    logic [IW-1:0]   mem_raddr;
    logic            mem_rdata_reg;

    logic [XW-1:0]   eff_size;
    logic [XW-1:0]   free_end;
    logic [XW-1:0]   found;
    logic            rsp_free;

    // The hall size saturates at the memory depth.
    assign eff_size = (XW'(hall_size_reg) > MAX_SLOTS_X) ? MAX_SLOTS_X
                                                        : XW'(hall_size_reg);
    assign free_end = XW'(req_item.free_start) + XW'(req_item.run_width);
    assign found    = XW'(rd_idx_reg) + XW'(1) - XW'(width_reg);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // Memory: one write port and one registered read port. Writes happen
    // only in the clearing pass and in the write phase, and read data is used
    // only in the scan, so a read that is used never meets a write to the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= slot_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hall_size_reg <= HALL_SIZE_RESET;
            clr_idx_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hall_size_reg <= hall_size_next;
            clr_idx_reg   <= clr_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg    <= width_next;
        issue_reg    <= issue_next;
        rd_idx_reg   <= rd_idx_next;
        run_reg      <= run_next;
        wr_idx_reg   <= wr_idx_next;
        wr_left_reg  <= wr_left_next;
        wr_val_reg   <= wr_val_next;
        res_reg      <= res_next;
        rsp_item_reg <= rsp_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        hall_size_next = cfg_we ? cfg_wdata : hall_size_reg;
        clr_idx_next   = clr_idx_reg;
        rd_pend_next   = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        width_next     = width_reg;
        issue_next     = issue_reg;
        rd_idx_next    = rd_idx_reg;
        run_next       = run_reg;
        wr_idx_next    = wr_idx_reg;
        wr_left_next   = wr_left_reg;
        wr_val_next    = wr_val_reg;
        res_next       = res_reg;
        rsp_item_next  = rsp_item_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_idx_reg;
        mem_wdata      = wr_val_reg;
        mem_raddr      = issue_reg[IW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = 1'b0;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    width_next         = req_item.run_width;
                    issue_next         = '0;
                    run_next           = '0;
                    res_next.run_start = '0;
                    wr_left_next       = req_item.run_width;
                    wr_idx_next        = IW'(req_item.free_start);
                    wr_val_next        = 1'b0;
                    if (req_item.operation == OP_ALLOC)
                    begin
                        if (req_item.run_width == 7'd0)
                        begin
                            res_next.status = ST_ALLOCATED;
                            state_next      = S_RESULT;
                        end
                        else if (XW'(req_item.run_width) > eff_size)
                        begin
                            res_next.status = ST_NO_SPACE;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_end > eff_size)
                        begin
                            res_next.status = ST_FREE_INVALID;
                            state_next      = S_RESULT;
                        end
                        else if (req_item.run_width == 7'd0)
                        begin
                            res_next.status = ST_FREED;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            res_next.status = ST_FREED;
                            state_next      = S_WRITE;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous slot is judged.
                if (issue_reg < eff_size)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = issue_reg[IW-1:0];
                    issue_next   = issue_reg + XW'(1);
                end
                if (rd_pend_reg)
                begin
                    if (mem_rdata_reg)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = run_reg + 7'd1;
                        if (run_reg + 7'd1 == width_reg)
                        begin
                            // Reads still in flight are dropped.
                            rd_pend_next       = 1'b0;
                            res_next.status    = ST_ALLOCATED;
                            res_next.run_start = found[5:0];
                            wr_idx_next        = found[IW-1:0];
                            wr_left_next       = width_reg;
                            wr_val_next        = 1'b1;
                            state_next         = S_WRITE;
                        end
                    end
                end
                else if (issue_reg >= eff_size)
                begin
                    res_next.status = ST_NO_SPACE;
                    state_next      = S_RESULT;
                end
            end

            S_WRITE:
            begin
                mem_we       = 1'b1;
                wr_idx_next  = wr_idx_reg + IW'(1);
                wr_left_next = wr_left_reg - 7'd1;
                if (wr_left_reg == 7'd1)
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_item_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The write phase stays inside the hall.
    a_write_in_hall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> XW'(wr_idx_reg) < eff_size)
        else $error("slot write outside the hall");

    // A scan never holds a free stretch as long as the requested width.
    a_run_below_width: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> run_reg < width_reg)
        else $error("free stretch reached width without a grant");

    // A finished item is posted as soon as the output register has room.
    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESULT && rsp_free |=> rsp_valid && state_reg == S_IDLE)
        else $error("result not posted");

    // Only a successful allocate reports a nonzero start.
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.status != ST_ALLOCATED |-> rsp_item.run_start == 6'd0)
        else $error("nonzero start on a result other than allocated");

endmodule
